[hdl/sese_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sese_pkg: shared types and constants of the scatter elements engine
// Field widths, operation codes, status codes and the queue word layout.
// ----------------------------------------------------------------------------
package sese_pkg;

	localparam int MAX_RANK    = 4;
	localparam int DIM_WIDTH   = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = 12;
	localparam int STORE_DEPTH = 2 ** ADDR_W;
	localparam int DIM_IDX_W   = $clog2(MAX_RANK);
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_ADDR_W  = 6;
	localparam int CFG_IDX_LSB = 3;

	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_SCATTER = 2'd1,
		MODE_READ    = 2'd2,
		MODE_RESTART = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_LOAD   = 3'd1,
		OP_READ   = 3'd2,
		OP_ASSIGN = 3'd3,
		OP_ADD    = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		REG_RANK        = 3'd0,
		REG_AXIS        = 3'd1,
		REG_REDUCE      = 3'd2,
		REG_TARGET_DIMS = 3'd3,
		REG_INDEX_DIMS  = 3'd4
	} reg_idx_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	localparam logic [2:0]  RANK_RESET = 3'd1;
	localparam logic [63:0] DIMS_RESET = 64'd281479271743489;

	typedef struct packed {
		logic [2:0]  rank;
		logic [1:0]  axis;
		logic        reduce;
		logic [63:0] target_dims;
		logic [63:0] index_dims;
	} cfg_t;

	typedef struct packed {
		op_t                    op;
		logic [ADDR_W-1:0]      addr;
		logic [VALUE_WIDTH-1:0] value;
		logic [1:0]             status;
	} entry_t;

	function automatic logic [DIM_WIDTH-1:0] extent(input logic [63:0] dims,
			input logic [DIM_IDX_W-1:0] d);
		return dims[16*d +: DIM_WIDTH];
	endfunction

endpackage

[hdl/sese_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sese_front: command intake and offset generation
// Classifies each word, checks pair indices, walks the coordinate counter and
// builds the flat offset one dimension per cycle before queueing the word.
// ----------------------------------------------------------------------------
module sese_front import sese_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          start,
	input  logic [1:0]                    mode,
	input  logic [ADDR_W-1:0]             address,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic signed [16:0]            index,
	input  logic                          q_full,
	output logic                          busy,
	output logic                          push,
	output entry_t                        push_entry
);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_ACC  = 2'b10
	} fstate_t;

	fstate_t                state_q;
	logic                   err_q;
	logic [DIM_WIDTH-1:0]   coord_q [MAX_RANK];
	logic [DIM_WIDTH-1:0]   coord_adv [MAX_RANK];
	logic [DIM_WIDTH-1:0]   idx_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [DIM_IDX_W-1:0]   d_q;
	logic [ADDR_W-1:0]      off_q;
	logic [ADDR_W-1:0]      stride_q;

	logic [2:0]             rank_eff;
	logic [2:0]             rank_m1;
	logic [DIM_IDX_W-1:0]   ax;
	logic [DIM_WIDTH-1:0]   ax_size;
	logic signed [17:0]     idx_w;
	logic signed [17:0]     size_w;
	logic                   in_range;
	logic [16:0]            idx_wrap;
	logic [DIM_WIDTH-1:0]   c_sel;
	logic [2*ADDR_W-1:0]    off_prod;
	logic [2*ADDR_W-1:0]    str_prod;
	logic [ADDR_W-1:0]      off_n;
	logic [ADDR_W-1:0]      ext_lo;
	logic                   accept;

	always_comb begin
		if (cfg.rank == 3'd0) begin
			rank_eff = 3'd1;
		end else if (cfg.rank > 3'(MAX_RANK)) begin
			rank_eff = 3'(MAX_RANK);
		end else begin
			rank_eff = cfg.rank;
		end
		rank_m1 = rank_eff - 3'd1;
		if ({1'b0, cfg.axis} >= rank_eff) begin
			ax = rank_m1[DIM_IDX_W-1:0];
		end else begin
			ax = cfg.axis;
		end
	end

	assign ax_size  = extent(cfg.target_dims, ax);
	assign idx_w    = {index[16], index};
	assign size_w   = {2'b00, ax_size};
	assign in_range = (idx_w < size_w) && (idx_w >= -size_w);
	assign idx_wrap = index[16] ? 17'(index + $signed({1'b0, ax_size})) : index;

	assign c_sel    = (d_q == ax) ? idx_q : coord_q[d_q];
	assign ext_lo   = ADDR_W'(extent(cfg.target_dims, d_q));
	assign off_prod = c_sel[ADDR_W-1:0] * stride_q;
	assign str_prod = ext_lo * stride_q;
	assign off_n    = off_q + off_prod[ADDR_W-1:0];

	// Row-major increment with carry from the last active dimension.
	always_comb begin
		logic                 carry;
		logic [DIM_WIDTH:0]   cur;
		carry = 1'b1;
		for (int d = MAX_RANK - 1; d >= 0; d--) begin
			coord_adv[d] = coord_q[d];
			cur = {1'b0, coord_q[d]} + 1'b1;
			if (carry && (d < int'(rank_eff))) begin
				if (cur < {1'b0, extent(cfg.index_dims, DIM_IDX_W'(d))}) begin
					coord_adv[d] = cur[DIM_WIDTH-1:0];
					carry = 1'b0;
				end else begin
					coord_adv[d] = '0;
				end
			end
		end
	end

	assign busy   = (state_q != F_IDLE) || q_full;
	assign accept = start && !busy;

	always_comb begin
		push       = 1'b0;
		push_entry = '{op: OP_NONE, addr: '0, value: '0, status: ST_OK};
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					case (mode_t'(mode))
						MODE_LOAD: begin
							push       = 1'b1;
							push_entry = '{op: OP_LOAD, addr: address, value: value,
								status: ST_OK};
						end
						MODE_READ: begin
							push       = 1'b1;
							push_entry = '{op: OP_READ, addr: address, value: '0,
								status: ST_OK};
						end
						MODE_RESTART: begin
							push = 1'b1;
						end
						default: begin
							if (err_q) begin
								push              = 1'b1;
								push_entry.status = ST_IGNORED;
							end else if (!in_range) begin
								push              = 1'b1;
								push_entry.status = ST_RANGE;
							end
						end
					endcase
				end
			end
			F_ACC: begin
				if (d_q == '0) begin
					push       = 1'b1;
					push_entry = '{op: cfg.reduce ? OP_ADD : OP_ASSIGN, addr: off_n,
						value: val_q, status: ST_OK};
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			err_q   <= 1'b0;
			for (int d = 0; d < MAX_RANK; d++) begin
				coord_q[d] <= '0;
			end
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept && (mode_t'(mode) == MODE_RESTART)) begin
						err_q <= 1'b0;
						for (int d = 0; d < MAX_RANK; d++) begin
							coord_q[d] <= '0;
						end
					end else if (accept && (mode_t'(mode) == MODE_SCATTER) && !err_q) begin
						if (in_range) begin
							state_q <= F_ACC;
						end else begin
							err_q <= 1'b1;
						end
					end
				end
				F_ACC: begin
					if (d_q == '0) begin
						state_q <= F_IDLE;
						coord_q <= coord_adv;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE) begin
			idx_q    <= idx_wrap[DIM_WIDTH-1:0];
			val_q    <= value;
			d_q      <= rank_m1[DIM_IDX_W-1:0];
			off_q    <= '0;
			stride_q <= ADDR_W'(1);
		end else begin
			off_q    <= off_n;
			stride_q <= str_prod[ADDR_W-1:0];
			d_q      <= d_q - 1'b1;
		end
	end

endmodule

[hdl/sese_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sese_queue: short word queue between intake and execution
// A small register FIFO that lets the front and the back stall separately.
// ----------------------------------------------------------------------------
module sese_queue import sese_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output logic   full,
	output logic   valid,
	output entry_t head
);

	entry_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

endmodule

[hdl/sese_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sese_back: tensor store and word execution
// Reads the store word, applies load, read, assign or add, writes it back for
// load, assign and add words and presents one registered result per word.
// ----------------------------------------------------------------------------
module sese_back import sese_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  entry_t                        q_head,
	output logic                          pop,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] read_data,
	output logic [ADDR_W-1:0]             target_address,
	output logic [1:0]                    status
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_EXEC = 2'b10
	} bstate_t;

	bstate_t                state_q;
	entry_t                 ent_q;
	logic [VALUE_WIDTH-1:0] rd_q;
	logic [VALUE_WIDTH-1:0] store_q [STORE_DEPTH];
	logic [VALUE_WIDTH-1:0] new_val;
	logic                   wr_en;
	logic                   done_q;
	logic [VALUE_WIDTH-1:0] data_q;
	logic [ADDR_W-1:0]      taddr_q;
	logic [1:0]             status_q;

	assign pop = (state_q == B_IDLE) && q_valid;

	always_comb begin
		new_val = '0;
		wr_en   = 1'b0;
		case (ent_q.op)
			OP_LOAD: begin
				new_val = ent_q.value;
				wr_en   = 1'b1;
			end
			OP_ASSIGN: begin
				new_val = ent_q.value;
				wr_en   = 1'b1;
			end
			OP_ADD: begin
				new_val = rd_q + ent_q.value;
				wr_en   = 1'b1;
			end
			OP_READ: begin
				new_val = rd_q;
			end
			default: begin
				new_val = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_q <= store_q[q_head.addr];
		end
		if ((state_q == B_EXEC) && wr_en) begin
			store_q[ent_q.addr] <= new_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == B_EXEC);
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						state_q <= B_EXEC;
					end
				end
				B_EXEC: begin
					state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= q_head;
		end
		if (state_q == B_EXEC) begin
			data_q   <= new_val;
			taddr_q  <= (ent_q.op == OP_NONE) ? '0 : ent_q.addr;
			status_q <= ent_q.status;
		end
	end

	assign done           = done_q;
	assign read_data      = data_q;
	assign target_address = taddr_q;
	assign status         = status_q;

endmodule

[hdl/scatter_elements_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatter_elements_engine_top: scatter elements along one axis
// Word store with load, read back and scatter pairs in assign or add mode.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Every word
// gives exactly one result, shown for one cycle with done high; the result
// side has no back pressure, so results must be captured when done is high.
// A scatter pair keeps the intake busy while its flat offset is built
// one dimension per cycle on a shared pair of 12-bit multipliers. The
// single-port store reads for each word and then writes back for loads,
// assigns and adds, and takes no new word until the last has executed;
// a two-word queue between intake and store lets both run at once. The
// store holds no defined contents after reset; read or add only words that
// were loaded. Configuration is written through the APB port at byte
// address 8*i. The user must write it only while no word is in flight;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module scatter_elements_engine_top import sese_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    mode,
	input  logic [ADDR_W-1:0]             address,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic signed [16:0]            index,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] read_data,
	output logic [ADDR_W-1:0]             target_address,
	output logic [1:0]                    status,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [CFG_ADDR_W-1:0]         paddr,
	input  logic [CFG_DATA_W-1:0]         pwdata,
	output logic [CFG_DATA_W-1:0]         prdata,
	output logic                          pready
);

	cfg_t     cfg_q;
	reg_idx_t reg_sel;
	logic     cfg_wr;
	logic     push;
	entry_t   push_entry;
	logic     q_full;
	logic     q_valid;
	entry_t   q_head;
	logic     pop;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[CFG_ADDR_W-1:CFG_IDX_LSB]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rank        <= RANK_RESET;
			cfg_q.axis        <= '0;
			cfg_q.reduce      <= 1'b0;
			cfg_q.target_dims <= DIMS_RESET;
			cfg_q.index_dims  <= DIMS_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_RANK:        cfg_q.rank        <= pwdata[2:0];
				REG_AXIS:        cfg_q.axis        <= pwdata[1:0];
				REG_REDUCE:      cfg_q.reduce      <= pwdata[0];
				REG_TARGET_DIMS: cfg_q.target_dims <= pwdata;
				REG_INDEX_DIMS:  cfg_q.index_dims  <= pwdata;
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_RANK:        prdata = {61'd0, cfg_q.rank};
			REG_AXIS:        prdata = {62'd0, cfg_q.axis};
			REG_REDUCE:      prdata = {63'd0, cfg_q.reduce};
			REG_TARGET_DIMS: prdata = cfg_q.target_dims;
			REG_INDEX_DIMS:  prdata = cfg_q.index_dims;
			default:         prdata = '0;
		endcase
	end

	sese_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.start      (start),
		.mode       (mode),
		.address    (address),
		.value      (value),
		.index      (index),
		.q_full     (q_full),
		.busy       (busy),
		.push       (push),
		.push_entry (push_entry)
	);

	sese_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.valid      (q_valid),
		.head       (q_head)
	);

	sese_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_head         (q_head),
		.pop            (pop),
		.done           (done),
		.read_data      (read_data),
		.target_address (target_address),
		.status         (status)
	);

endmodule
